FILE: hw/rtl/ald_pkg.sv
package ald_pkg;

  // Default widths of the sample and time fields
  localparam int ADC_BITS_DEF  = 10;
  localparam int TIME_BITS_DEF = 32;

  localparam int NUM_BUTTONS   = 3;
  localparam int DEBOUNCE_BITS = 16;

  // Configuration channel
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DEBOUNCE_MS = 3'd0,
    CFG_FIRST_LOW   = 3'd1,
    CFG_FIRST_HIGH  = 3'd2,
    CFG_SECOND_LOW  = 3'd3,
    CFG_SECOND_HIGH = 3'd4,
    CFG_THIRD_LOW   = 3'd5
  } cfg_idx_t;

  // Slots of the window bound array
  localparam int NUM_BOUNDS = 5;
  typedef enum logic [2:0] {
    BND_FIRST_LOW   = 3'd0,
    BND_FIRST_HIGH  = 3'd1,
    BND_SECOND_LOW  = 3'd2,
    BND_SECOND_HIGH = 3'd3,
    BND_THIRD_LOW   = 3'd4
  } bound_t;

  // Button slots
  localparam int BTN_FIRST  = 0;
  localparam int BTN_SECOND = 1;
  localparam int BTN_THIRD  = 2;

  // Register values after reset
  localparam logic [DEBOUNCE_BITS-1:0] RST_DEBOUNCE_MS = 16'd50;
  localparam int RST_FIRST_LOW   = 450;
  localparam int RST_FIRST_HIGH  = 500;
  localparam int RST_SECOND_LOW  = 600;
  localparam int RST_SECOND_HIGH = 700;
  localparam int RST_THIRD_LOW   = 900;

endpackage

FILE: hw/rtl/ald_in_if.sv
interface ald_in_if
  import ald_pkg::*;
#(
  parameter int ADC_BITS  = ADC_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [ADC_BITS-1:0]  adc_sample;
  logic [TIME_BITS-1:0] now_ms;

  modport source (output valid, output adc_sample, output now_ms, input ready);
  modport sink   (input valid, input adc_sample, input now_ms, output ready);
endinterface

FILE: hw/rtl/ald_out_if.sv
interface ald_out_if;
  logic valid;
  logic ready;
  logic press_first;
  logic press_second;
  logic press_third;

  modport source (output valid, output press_first, output press_second,
                  output press_third, input ready);
  modport sink   (input valid, input press_first, input press_second,
                  input press_third, output ready);
endinterface

FILE: hw/rtl/ald_cfg_if.sv
interface ald_cfg_if
  import ald_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/analog_ladder_button_debounce.sv
// Three-button resistor-ladder decoder with per-button debounce.
//
// in_ch  : one beat per converter sample (adc_sample) with its millisecond
//          timestamp (now_ms). valid/ready handshake.
// out_ch : one beat per input beat, in order, carrying press_first,
//          press_second and press_third; a flag is 1 only on the sample at
//          which that button's debounced level turns to pressed.
// cfg_ch : register writes (index, data), always ready. Index 0 is the
//          debounce time in ms, 1..5 the window bounds; other indexes are
//          ignored. Write only while no beats are in flight.
//
// An input beat reaches its output beat through an input register,
// then window compare, timer subtract and compare into the output register.
// Throughput is one beat per cycle. When out_ch stalls, the input register
// still takes one more beat; then in_ch.ready drops until out_ch drains.
// Reset (rst_n low, synchronous) restores the register defaults, clears
// all button state to released and empties the pipeline.
module analog_ladder_button_debounce
  import ald_pkg::*;
#(
  parameter int ADC_BITS  = ADC_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  ald_in_if.sink       in_ch,
  ald_out_if.source    out_ch,
  ald_cfg_if.sink      cfg_ch
);

  logic [DEBOUNCE_BITS-1:0]            debounce_ms;
  logic [NUM_BOUNDS-1:0][ADC_BITS-1:0] bounds;

  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic [ADC_BITS-1:0]    s1_sample_r;
  logic [TIME_BITS-1:0]   s1_now_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [NUM_BUTTONS-1:0] out_press_r;

  logic                   out_free;
  logic                   s1_adv;
  logic                   in_acc;
  logic [NUM_BUTTONS-1:0] raw;
  logic [NUM_BUTTONS-1:0] pulse;

  ald_cfg_regs #(.ADC_BITS(ADC_BITS)) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_ch      (cfg_ch),
    .debounce_ms (debounce_ms),
    .bounds      (bounds)
  );

  // Pipeline handshake
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_ch.adc_sample;
      s1_now_r    <= in_ch.now_ms;
    end
  end

  // Window decode and one debouncer per button
  ald_window #(.ADC_BITS(ADC_BITS)) u_window (
    .sample (s1_sample_r),
    .bounds (bounds),
    .raw    (raw)
  );

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
    ald_debounce #(.TIME_BITS(TIME_BITS)) u_deb (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (s1_adv),
      .raw         (raw[b]),
      .now_ms      (s1_now_r),
      .debounce_ms (debounce_ms),
      .pulse       (pulse[b])
    );
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_press_r <= pulse;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.press_first  = out_press_r[BTN_FIRST];
  assign out_ch.press_second = out_press_r[BTN_SECOND];
  assign out_ch.press_third  = out_press_r[BTN_THIRD];

endmodule

FILE: hw/rtl/ald_cfg_regs.sv
module ald_cfg_regs
  import ald_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  ald_cfg_if.sink                               cfg_ch,
  output logic [DEBOUNCE_BITS-1:0]              debounce_ms,
  output logic [NUM_BOUNDS-1:0][ADC_BITS-1:0]   bounds
);

  logic [DEBOUNCE_BITS-1:0]            debounce_r;
  logic [NUM_BOUNDS-1:0][ADC_BITS-1:0] bounds_r;
  logic                                wr_en;

  // Writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r                <= RST_DEBOUNCE_MS;
      bounds_r[BND_FIRST_LOW]   <= ADC_BITS'(RST_FIRST_LOW);
      bounds_r[BND_FIRST_HIGH]  <= ADC_BITS'(RST_FIRST_HIGH);
      bounds_r[BND_SECOND_LOW]  <= ADC_BITS'(RST_SECOND_LOW);
      bounds_r[BND_SECOND_HIGH] <= ADC_BITS'(RST_SECOND_HIGH);
      bounds_r[BND_THIRD_LOW]   <= ADC_BITS'(RST_THIRD_LOW);
    end else if (wr_en) begin
      case (cfg_ch.index)
        CFG_DEBOUNCE_MS: debounce_r                <= cfg_ch.data[DEBOUNCE_BITS-1:0];
        CFG_FIRST_LOW:   bounds_r[BND_FIRST_LOW]   <= cfg_ch.data[ADC_BITS-1:0];
        CFG_FIRST_HIGH:  bounds_r[BND_FIRST_HIGH]  <= cfg_ch.data[ADC_BITS-1:0];
        CFG_SECOND_LOW:  bounds_r[BND_SECOND_LOW]  <= cfg_ch.data[ADC_BITS-1:0];
        CFG_SECOND_HIGH: bounds_r[BND_SECOND_HIGH] <= cfg_ch.data[ADC_BITS-1:0];
        CFG_THIRD_LOW:   bounds_r[BND_THIRD_LOW]   <= cfg_ch.data[ADC_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign debounce_ms = debounce_r;
  assign bounds      = bounds_r;

endmodule

FILE: hw/rtl/ald_window.sv
module ald_window
  import ald_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic [ADC_BITS-1:0]                  sample,
  input  logic [NUM_BOUNDS-1:0][ADC_BITS-1:0]  bounds,
  output logic [NUM_BUTTONS-1:0]               raw
);

  logic hit_first;
  logic hit_second;
  logic hit_third;

  // Open windows, first match wins
  assign hit_first  = (sample > bounds[BND_FIRST_LOW]) && (sample < bounds[BND_FIRST_HIGH]);
  assign hit_second = (sample > bounds[BND_SECOND_LOW]) && (sample < bounds[BND_SECOND_HIGH]);
  assign hit_third  = (sample > bounds[BND_THIRD_LOW]);

  always_comb begin
    raw = '0;
    if (hit_first) begin
      raw[BTN_FIRST] = 1'b1;
    end else if (hit_second) begin
      raw[BTN_SECOND] = 1'b1;
    end else if (hit_third) begin
      raw[BTN_THIRD] = 1'b1;
    end
  end

endmodule

FILE: hw/rtl/ald_debounce.sv
module ald_debounce
  import ald_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     raw,
  input  logic [TIME_BITS-1:0]     now_ms,
  input  logic [DEBOUNCE_BITS-1:0] debounce_ms,
  output logic                     pulse
);

  logic                 prev_r;
  logic                 stable_r;
  logic [TIME_BITS-1:0] change_r;
  logic [TIME_BITS-1:0] change_nxt;
  logic [TIME_BITS-1:0] elapsed;
  logic                 settled;
  logic                 take;

  // A raw edge restarts the timer; elapsed time wraps with now_ms
  assign change_nxt = (raw != prev_r) ? now_ms : change_r;
  assign elapsed    = now_ms - change_nxt;
  assign settled    = elapsed > TIME_BITS'(debounce_ms);
  assign take       = settled && (raw != stable_r);
  assign pulse      = take && raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= 1'b0;
      stable_r <= 1'b0;
      change_r <= '0;
    end else if (en) begin
      prev_r   <= raw;
      change_r <= change_nxt;
      if (take) begin
        stable_r <= raw;
      end
    end
  end

endmodule
